// ===== hdl/gsm_pkg.sv =====
// shared types, widths and fixed-point helpers for the golden-section minimizer
// no dependencies; used by every module of the block
package gsm_pkg;

  localparam int PT_W          = 21;
  localparam int SPAN_W        = 22;
  localparam int TOL_W         = 21;
  localparam int STEPS_W       = 7;
  localparam int MUL_W         = 33;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int VAL_W         = 40;
  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 21'd2949;

  // saturation bounds for the polynomial intermediates
  localparam logic signed [PROD_W-1:0] S_HI = 66'sh000000000_80000000;
  localparam logic signed [PROD_W-1:0] S_LO = -S_HI;
  localparam logic signed [PROD_W-1:0] V_HI = 66'sh0000000_7FFFFFFFFF;
  localparam logic signed [PROD_W-1:0] V_LO = -V_HI - 66'sd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PT,
    ST_PTW,
    ST_SQ,
    ST_SQW,
    ST_CU,
    ST_CUW,
    ST_V,
    ST_VW
  } gsm_state_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // round-to-nearest golden ratio fraction at the given number of fraction bits
  function automatic logic signed [MUL_W-1:0] phi_q(input int frac);
    longint unsigned t;
    t = 64'd2654435769 + (64'd1 << (31 - frac));
    return MUL_W'(t >> (32 - frac));
  endfunction

  function automatic logic signed [MUL_W-1:0] sat_s(input logic signed [PROD_W-1:0] v);
    if (v > S_HI) begin
      return S_HI[MUL_W-1:0];
    end else if (v < S_LO) begin
      return S_LO[MUL_W-1:0];
    end
    return v[MUL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_v(input logic signed [PROD_W-1:0] v);
    if (v > V_HI) begin
      return V_HI[VAL_W-1:0];
    end else if (v < V_LO) begin
      return V_LO[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

// ===== hdl/gsm_mul.sv =====
// shared signed multiplier with registered product
// depends on gsm_pkg for operand widths and the request struct
module gsm_mul (
  input  logic                              clk,
  input  gsm_pkg::mul_req_t                 req,
  output logic signed [gsm_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

// ===== hdl/gsm_seq.sv =====
// sequencer and datapath registers of the golden-section search
// depends on gsm_pkg; drives the shared multiplier gsm_mul
module gsm_seq #(
  parameter int MAX_STEPS = gsm_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = gsm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [gsm_pkg::PT_W-1:0]    lo_end,
  input  logic signed [gsm_pkg::PT_W-1:0]    hi_end,
  input  logic        [gsm_pkg::TOL_W-1:0]   tol,
  output logic                               busy,
  output logic                               done,
  output logic signed [gsm_pkg::PT_W-1:0]    x_min,
  output logic        [gsm_pkg::STEPS_W-1:0] steps_taken,
  output logic                               hit_cap,
  output gsm_pkg::mul_req_t                  mul_req,
  input  logic signed [gsm_pkg::PROD_W-1:0]  prod
);

  localparam int PT_W    = gsm_pkg::PT_W;
  localparam int SPAN_W  = gsm_pkg::SPAN_W;
  localparam int MUL_W   = gsm_pkg::MUL_W;
  localparam int PROD_W  = gsm_pkg::PROD_W;
  localparam int VAL_W   = gsm_pkg::VAL_W;
  localparam int STEP_CW = $clog2(MAX_STEPS + 1);
  localparam logic signed [MUL_W-1:0] ONE_Q = MUL_W'(64'd1 << FRAC_BITS);
  localparam logic signed [MUL_W-1:0] PHI_Q = gsm_pkg::phi_q(FRAC_BITS);
  localparam logic signed [MUL_W-1:0] PHI_C = ONE_Q - PHI_Q;

  gsm_pkg::gsm_state_t state, state_next;

  logic signed [PT_W-1:0]   left_end, right_end, inner_low, inner_high, x_pt;
  logic signed [VAL_W-1:0]  value_low, value_high;
  logic signed [SPAN_W-1:0] span;
  logic signed [MUL_W-1:0]  s_val, one_m_s, one_m_c;
  logic [STEP_CW-1:0]       step_count;
  logic                     primed, pending_high, target_high;

  logic signed [SPAN_W-1:0] width_w, sum_w, new_span;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PT_W-1:0]   new_pt;
  logic                     go_on, at_cap, take_low;

  assign width_w  = SPAN_W'(right_end) - SPAN_W'(left_end);
  assign sum_w    = SPAN_W'(right_end) + SPAN_W'(left_end);
  assign go_on    = width_w >= $signed({1'b0, tol});
  assign at_cap   = step_count >= STEP_CW'(MAX_STEPS);
  assign take_low = value_low <= value_high;
  assign new_span = take_low ? SPAN_W'(inner_high) - SPAN_W'(left_end)
                             : SPAN_W'(right_end) - SPAN_W'(inner_low);
  assign prod_sh  = prod >>> FRAC_BITS;
  // offset from left is within the span, so the low bits of the shifted product suffice
  assign new_pt   = PT_W'(SPAN_W'(left_end) + prod_sh[SPAN_W-1:0]);

  assign busy = (state != gsm_pkg::ST_IDLE) || rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_req    = '{en: 1'b0, a: '0, b: '0};
    case (state)
      gsm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = gsm_pkg::ST_CHECK;
        end
      end
      gsm_pkg::ST_CHECK: begin
        if (!go_on || (primed && at_cap)) begin
          state_next = gsm_pkg::ST_IDLE;
        end else begin
          state_next = gsm_pkg::ST_PT;
        end
      end
      gsm_pkg::ST_PT: begin
        mul_req    = '{en: 1'b1, a: MUL_W'(span), b: target_high ? PHI_Q : PHI_C};
        state_next = gsm_pkg::ST_PTW;
      end
      gsm_pkg::ST_PTW: state_next = gsm_pkg::ST_SQ;
      gsm_pkg::ST_SQ: begin
        mul_req    = '{en: 1'b1, a: MUL_W'(x_pt), b: MUL_W'(x_pt)};
        state_next = gsm_pkg::ST_SQW;
      end
      gsm_pkg::ST_SQW: state_next = gsm_pkg::ST_CU;
      gsm_pkg::ST_CU: begin
        mul_req    = '{en: 1'b1, a: s_val, b: MUL_W'(x_pt)};
        state_next = gsm_pkg::ST_CUW;
      end
      gsm_pkg::ST_CUW: state_next = gsm_pkg::ST_V;
      gsm_pkg::ST_V: begin
        mul_req    = '{en: 1'b1, a: one_m_s, b: one_m_c};
        state_next = gsm_pkg::ST_VW;
      end
      gsm_pkg::ST_VW: begin
        state_next = pending_high ? gsm_pkg::ST_PT : gsm_pkg::ST_CHECK;
      end
      default: state_next = gsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == gsm_pkg::ST_CHECK) && (!go_on || (primed && at_cap));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gsm_pkg::ST_IDLE: begin
        if (start && !rst) begin
          left_end     <= lo_end;
          right_end    <= hi_end;
          step_count   <= '0;
          primed       <= 1'b0;
          pending_high <= 1'b0;
        end
      end
      gsm_pkg::ST_CHECK: begin
        if (!go_on || (primed && at_cap)) begin
          x_min       <= sum_w[SPAN_W-1:1];
          steps_taken <= gsm_pkg::STEPS_W'(step_count);
          hit_cap     <= go_on;
        end else if (!primed) begin
          // first pass: both inner points of the starting interval
          primed       <= 1'b1;
          pending_high <= 1'b1;
          target_high  <= 1'b0;
          span         <= width_w;
        end else begin
          step_count <= step_count + STEP_CW'(1);
          span       <= new_span;
          if (take_low) begin
            right_end   <= inner_high;
            inner_high  <= inner_low;
            value_high  <= value_low;
            target_high <= 1'b0;
          end else begin
            left_end    <= inner_low;
            inner_low   <= inner_high;
            value_low   <= value_high;
            target_high <= 1'b1;
          end
        end
      end
      gsm_pkg::ST_PTW: begin
        x_pt <= new_pt;
        if (target_high) begin
          inner_high <= new_pt;
        end else begin
          inner_low <= new_pt;
        end
      end
      gsm_pkg::ST_SQW: s_val <= gsm_pkg::sat_s(prod_sh);
      gsm_pkg::ST_CUW: begin
        one_m_s <= ONE_Q - s_val;
        one_m_c <= ONE_Q - gsm_pkg::sat_s(prod_sh);
      end
      gsm_pkg::ST_VW: begin
        if (target_high) begin
          value_high <= gsm_pkg::sat_v(prod_sh);
        end else begin
          value_low <= gsm_pkg::sat_v(prod_sh);
        end
        if (pending_high) begin
          pending_high <= 1'b0;
          target_high  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/golden_section_minimizer.sv =====
// golden-section minimizer of (1-x^2)(1-x^3) over a signed Q4.16 interval
//
// usage: load the tolerance with cfg_we/cfg_data while the block is idle
// (reset value about 0.045). Start a transaction by raising start with
// lo_end and hi_end while busy is low; the ends are taken at that edge.
// busy stays high until the search ends. The result (x_min, steps_taken,
// hit_cap) is shown for exactly one cycle with done high; the receiver
// cannot stall it, and a new start may be given in the done cycle.
//
// one shared 33x33 multiplier does all the work, each product followed by a
// wait state: a new inner point and its polynomial value take four products,
// plus a compare and update in the check state per narrowing step.
// done is registered from the check state that ends the search, which is the
// first check when the interval is already narrow, else the one after N steps,
// N at most MAX_STEPS. One transaction is in flight at a time.
// synchronous reset returns the sequencer to idle, drops done and restores
// the tolerance register; busy reads high while reset is held.
// depends on gsm_pkg, gsm_mul and gsm_seq
module golden_section_minimizer #(
  parameter int MAX_STEPS = gsm_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = gsm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gsm_pkg::PT_W-1:0]    lo_end,
  input  logic signed [gsm_pkg::PT_W-1:0]    hi_end,
  input  logic                               cfg_we,
  input  logic        [gsm_pkg::TOL_W-1:0]   cfg_data,
  output logic                               done,
  output logic signed [gsm_pkg::PT_W-1:0]    x_min,
  output logic        [gsm_pkg::STEPS_W-1:0] steps_taken,
  output logic                               hit_cap
);

  logic [gsm_pkg::TOL_W-1:0]         tolerance;
  gsm_pkg::mul_req_t                 mul_req;
  logic signed [gsm_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= gsm_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_data;
    end
  end

  gsm_seq #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .lo_end      (lo_end),
    .hi_end      (hi_end),
    .tol         (tolerance),
    .busy        (busy),
    .done        (done),
    .x_min       (x_min),
    .steps_taken (steps_taken),
    .hit_cap     (hit_cap),
    .mul_req     (mul_req),
    .prod        (prod)
  );

  gsm_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

endmodule

// ===== hdl/gsm_checker.sv =====
// port-level assertions for golden_section_minimizer, with its bind
// depends on gsm_pkg for field widths
module gsm_checker #(
  parameter int MAX_STEPS = gsm_pkg::MAX_STEPS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic        [gsm_pkg::STEPS_W-1:0] steps_taken,
  input logic                               hit_cap
);

  // a result always comes from a finished search, so the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not hold busy");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (steps_taken <= gsm_pkg::STEPS_W'(MAX_STEPS)))
    else $error("step count beyond cap");

  a_cap_steps: assert property (@(posedge clk) disable iff (rst)
    (done && hit_cap) |-> (steps_taken == gsm_pkg::STEPS_W'(MAX_STEPS)))
    else $error("cap flag without full step count");

endmodule

bind golden_section_minimizer gsm_checker #(
  .MAX_STEPS (MAX_STEPS)
) u_gsm_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .steps_taken (steps_taken),
  .hit_cap     (hit_cap)
);

// ===== sim/golden_section_minimizer_test.sv =====
// self-checking testbench for golden_section_minimizer: directed and random intervals
// over several tolerance settings, checked against a behavioral golden-section search
// depends on gsm_pkg and golden_section_minimizer
module golden_section_minimizer_test;

  localparam int     PT_W          = gsm_pkg::PT_W;
  localparam int     STEPS_W       = gsm_pkg::STEPS_W;
  localparam int     TOL_W         = gsm_pkg::TOL_W;
  localparam int     FRAC          = gsm_pkg::FRAC_BITS_DEF;
  localparam int     STEP_CAP      = gsm_pkg::MAX_STEPS_DEF;
  localparam longint ONE           = 64'sd1 << FRAC;
  localparam longint GOLD          =
    longint'((64'd2654435769 + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
  localparam longint GOLD_C        = ONE - GOLD;
  localparam longint LIM31         = 64'sd1 << 31;
  localparam longint LIM39         = 64'sd1 << 39;
  localparam int     PT_MIN        = -524288;
  localparam int     PT_SPAN       = 1048576;
  localparam int     PER_PHASE     = 220;
  localparam int     DRAIN_CYCLES  = 800;
  localparam int     CYCLE_LIMIT   = 6000000;

  typedef struct packed {
    logic signed [PT_W-1:0] lo;
    logic signed [PT_W-1:0] hi;
  } interval_t;

  typedef struct packed {
    logic signed [PT_W-1:0]    x_min;
    logic        [STEPS_W-1:0] steps;
    logic                      cap;
  } search_result_t;

  typedef struct packed {
    interval_t      span;
    search_result_t res;
  } minimum_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [PT_W-1:0]    lo_end = '0;
  logic signed [PT_W-1:0]    hi_end = '0;
  logic                      cfg_we = 1'b0;
  logic        [TOL_W-1:0]   cfg_data = '0;
  logic                      done;
  logic signed [PT_W-1:0]    x_min;
  logic        [STEPS_W-1:0] steps_taken;
  logic                      hit_cap;

  interval_t       intervals_q[$];
  minimum_t        minima_q[$];
  logic [TOL_W-1:0] tol_setting = gsm_pkg::TOL_RESET;
  int              mismatches = 0;
  int              cycle_count = 0;
  int              gap_left = 0;
  int              burst_left = 1;

  golden_section_minimizer #(
    .MAX_STEPS(gsm_pkg::MAX_STEPS_DEF),
    .FRAC_BITS(gsm_pkg::FRAC_BITS_DEF)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .lo_end(lo_end),
    .hi_end(hi_end),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .x_min(x_min),
    .steps_taken(steps_taken),
    .hit_cap(hit_cap)
  );

  always #5 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // (1-x^2)(1-x^3) with truncating shifts and saturated intermediates
  function automatic longint curve_at(longint x);
    longint sq, cu;
    sq = clip((x * x) >>> FRAC, -LIM31, LIM31);
    cu = clip((sq * x) >>> FRAC, -LIM31, LIM31);
    return clip(((ONE - sq) * (ONE - cu)) >>> FRAC, -LIM39, LIM39 - 1);
  endfunction

  function automatic longint golden_cut(longint a, longint b, longint k);
    return a + ((k * (b - a)) >>> FRAC);
  endfunction

  function automatic search_result_t golden_search(logic signed [PT_W-1:0] lo,
                                                   logic signed [PT_W-1:0] hi,
                                                   logic [TOL_W-1:0] tol);
    longint a, b, p, q, fp, fq, stop_width;
    int n;
    logic capped;
    search_result_t r;
    a = lo;
    b = hi;
    stop_width = tol;
    p = golden_cut(a, b, GOLD_C);
    q = golden_cut(a, b, GOLD);
    fp = curve_at(p);
    fq = curve_at(q);
    n = 0;
    capped = 1'b0;
    while (b - a >= stop_width) begin
      if (n >= STEP_CAP) begin
        capped = 1'b1;
        break;
      end
      n++;
      // ties drop the right part
      if (fp <= fq) begin
        b = q;
        q = p;
        fq = fp;
        p = golden_cut(a, b, GOLD_C);
        fp = curve_at(p);
      end else begin
        a = p;
        p = q;
        fp = fq;
        q = golden_cut(a, b, GOLD);
        fq = curve_at(q);
      end
    end
    r.x_min = PT_W'((a + b) >>> 1);
    r.steps = STEPS_W'(n);
    r.cap = capped;
    return r;
  endfunction

  function automatic interval_t make_interval(int lo, int hi);
    interval_t s;
    s.lo = PT_W'(lo);
    s.hi = PT_W'(hi);
    return s;
  endfunction

  // mostly ordered intervals with widths spread over many octaves
  function automatic interval_t random_interval(logic [TOL_W-1:0] tol);
    int mode, m, base;
    mode = $urandom_range(0, 19);
    if (mode >= 18) begin
      return make_interval(int'($urandom_range(0, PT_SPAN)) + PT_MIN,
                           int'($urandom_range(0, PT_SPAN)) + PT_MIN);
    end
    if (mode < 14) begin
      m = $urandom_range(0, 1 << $urandom_range(2, 20));
    end else if (mode < 16) begin
      m = $urandom_range(0, int'(tol) - 1);
    end else begin
      m = $urandom_range(1, PT_SPAN);
    end
    base = int'($urandom_range(0, PT_SPAN - m)) + PT_MIN;
    if (mode < 16) begin
      return make_interval(base, base + m);
    end
    return make_interval(base + m, base);
  endfunction

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    interval_t nxt;
    logic took;
    minimum_t m;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      took = start && !busy;
      if (took) begin
        m.span = make_interval(lo_end, hi_end);
        m.res = golden_search(lo_end, hi_end, tol_setting);
        minima_q.push_back(m);
      end
      if (start && !took) begin
        // hold the request until the block takes it
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
        lo_end <= PT_W'($urandom);
        hi_end <= PT_W'($urandom);
      end else if (intervals_q.size() != 0) begin
        nxt = intervals_q.pop_front();
        lo_end <= nxt.lo;
        hi_end <= nxt.hi;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 4))
            0, 1: gap_left = 0;
            2, 3: gap_left = $urandom_range(1, 8);
            default: gap_left = $urandom_range(9, 300);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // receiver: every done cycle carries one transaction
  always @(posedge clk) begin
    minimum_t m;
    if (!rst && done) begin
      if (minima_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: x_min=%0d steps=%0d cap=%0b",
                   x_min, steps_taken, hit_cap);
        end
        mismatches++;
      end else begin
        m = minima_q.pop_front();
        if (x_min !== m.res.x_min || steps_taken !== m.res.steps ||
            hit_cap !== m.res.cap) begin
          if (mismatches < 10) begin
            $display("mismatch [%0d,%0d]: exp x_min=%0d steps=%0d cap=%0b, got %0d %0d %0b",
                     m.span.lo, m.span.hi, m.res.x_min, m.res.steps, m.res.cap,
                     x_min, steps_taken, hit_cap);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (intervals_q.size() != 0 || start || busy || minima_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic load_tolerance(input logic [TOL_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_setting = v;
    @(negedge clk);
  endtask

  initial begin
    int unsigned tol_plan[7];
    tol_plan = '{1048576, 0, 65536, 0, 4, 0, 2949};
    tol_plan[1] = $urandom_range(4, 1048576);
    tol_plan[3] = $urandom_range(4, 64);
    tol_plan[5] = $urandom_range(4, 8192);

    // reset tolerance: range extremes, reversed and zero-width ends, width at the stop
    intervals_q.push_back(make_interval(-524288, 524288));
    intervals_q.push_back(make_interval(524288, -524288));
    intervals_q.push_back(make_interval(-524288, -524288));
    intervals_q.push_back(make_interval(524288, 524288));
    intervals_q.push_back(make_interval(0, 0));
    intervals_q.push_back(make_interval(-524288, 0));
    intervals_q.push_back(make_interval(0, 524288));
    intervals_q.push_back(make_interval(64536, 66536));
    intervals_q.push_back(make_interval(0, 131072));
    intervals_q.push_back(make_interval(-131072, 131072));
    intervals_q.push_back(make_interval(100, 3049));
    intervals_q.push_back(make_interval(100, 3048));
    intervals_q.push_back(make_interval(-1, 0));
    intervals_q.push_back(make_interval(-524288, -524287));
    intervals_q.push_back(make_interval(524287, 524288));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // finest tolerance: flat region near zero gives equal values
    load_tolerance(21'd4);
    intervals_q.push_back(make_interval(-200, 200));
    intervals_q.push_back(make_interval(-100, 100));
    intervals_q.push_back(make_interval(0, 4));
    intervals_q.push_back(make_interval(0, 3));
    intervals_q.push_back(make_interval(-524288, 524288));
    intervals_q.push_back(make_interval(10, 5));
    intervals_q.push_back(make_interval(-65536, 65536));
    wait_idle();

    foreach (tol_plan[p]) begin
      load_tolerance(TOL_W'(tol_plan[p]));
      for (int i = 0; i < PER_PHASE; i++) begin
        intervals_q.push_back(random_interval(tol_setting));
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && minima_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== golden_section_minimizer.f =====
hdl/gsm_pkg.sv
hdl/gsm_mul.sv
hdl/gsm_seq.sv
hdl/golden_section_minimizer.sv
hdl/gsm_checker.sv
sim/golden_section_minimizer_test.sv
